// ----- rtl/epdsa_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// epdsa_pkg - shared types and constants of the scrambled address core
// Mode bit positions, register indexes, field widths and the lane record
// that travels from the mapping stages through the remainder pipeline.
// ----------------------------------------------------------------------------
package epdsa_pkg;

   localparam int MaxLines = 2048;
   localparam int COORD_W  = $clog2(MaxLines);     // coordinate width
   localparam int CNT_W    = COORD_W + 1;          // configured line counts
   localparam int GEOM_W   = CNT_W + 1;            // scrambled line counts
   localparam int MODE_W   = 9;
   localparam int PIX_W    = 8;
   localparam int ADDR_W   = 22;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = CNT_W;

   // remainder pipeline: stages and quotient bits resolved per stage
   localparam int REM_STAGES = 4;
   localparam int REM_BITS   = 4;
   localparam int MAG_W      = REM_STAGES * REM_BITS;
   localparam int COL_W      = MAG_W;              // signed column value
   localparam int ROW_W      = CNT_W;              // row after scramble
   localparam int ROWS_W     = GEOM_W + 2;         // signed row after reverse

   // scramble_mode bit positions
   localparam int MODE_SRC_SCR   = 0;
   localparam int MODE_GATE_SCR  = 1;
   localparam int MODE_FIRST_ODD = 2;
   localparam int MODE_INTERLACE = 3;
   localparam int MODE_IL_ODD    = 4;
   localparam int MODE_MIRROR    = 5;
   localparam int MODE_SRC_REV   = 6;
   localparam int MODE_SRC_ROT   = 7;
   localparam int MODE_GATE_REV  = 8;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MODE         = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GATE_LINES   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SOURCE_LINES = 2'd2;

   // configuration as seen by the datapath, line counts already scrambled
   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [GEOM_W-1:0] gate_cnt;
      logic [GEOM_W-1:0] src_cnt;
   } geom_type;

   // one pixel in flight between the mapping and the address stages
   typedef struct packed {
      logic signed [COL_W-1:0] col;      // column before rotation
      logic                    neg;      // rotation dividend is negative
      logic [MAG_W-1:0]        mag;      // magnitude of rotation dividend
      logic [GEOM_W-1:0]       rem;      // partial remainder
      logic [ROW_W-1:0]        row;
      logic [PIX_W-1:0]        pix;
   } lane_type;

endpackage
`default_nettype wire

// ----- rtl/epd_pixel_scramble_address_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// epd_pixel_scramble_address_core - scrambled frame store address generator
// Maps each pixel with its gate-line and source-line coordinates to its
// address in the panel's scrambled frame store.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one pixel beat (gate line, source line, pixel byte),
//   rsp_* returns its target address, the pixel and the scrambled line
//   counts. Both use valid/stall; a beat moves when valid is high and
//   stall is low.
//   csr_* writes scramble_mode, gate_lines and source_lines; write only
//   while no beat is in flight.
//   A beat passes three mapping stages, four remainder stages of the
//   half-row rotation (four dividend bits each) and three address stages
//   with the row multiply.
//   Throughput is one beat per cycle while rsp_stall is low. Each stage
//   holds its beat while the next is full, so a stalled response fills the
//   pipeline before req_stall rises, and empty stages are closed up.
//   Synchronous reset empties the pipeline and sets mode 0 with one gate
//   line and one source line.
// ----------------------------------------------------------------------------
module epd_pixel_scramble_address_core (
   input  wire                                 clock,
   input  wire                                 reset,
   // configuration
   input  wire                                 csr_wr_en,
   input  wire [epdsa_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire [epdsa_pkg::CSR_DATA_W-1:0]     csr_wr_data,
   // request
   input  wire                                 req_valid,
   output logic                                req_stall,
   input  wire [epdsa_pkg::COORD_W-1:0]        req_gate_line,
   input  wire [epdsa_pkg::COORD_W-1:0]        req_source_line,
   input  wire [epdsa_pkg::PIX_W-1:0]          req_pixel_in,
   // response
   output logic                                rsp_valid,
   input  wire                                 rsp_stall,
   output logic [epdsa_pkg::ADDR_W-1:0]        rsp_target_index,
   output logic [epdsa_pkg::PIX_W-1:0]         rsp_pixel_out,
   output logic [epdsa_pkg::GEOM_W-1:0]        rsp_out_gate_lines,
   output logic [epdsa_pkg::GEOM_W-1:0]        rsp_out_source_lines
);

   localparam int CNTW = epdsa_pkg::CNT_W;

   logic [epdsa_pkg::MODE_W-1:0]  mode_ff, mode_in;
   logic [CNTW-1:0]               gate_lines_ff, gate_lines_in;
   logic [CNTW-1:0]               source_lines_ff, source_lines_in;

   epdsa_pkg::geom_type  geom;
   logic                 src_scr, gate_scr;

   logic                 map_ready, map_valid, rem_ready, rem_valid, addr_ready;
   epdsa_pkg::lane_type  map_lane, rem_lane;

   always_comb begin
      mode_in         = mode_ff;
      gate_lines_in   = gate_lines_ff;
      source_lines_in = source_lines_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            epdsa_pkg::CSR_MODE:         mode_in = csr_wr_data[epdsa_pkg::MODE_W-1:0];
            epdsa_pkg::CSR_GATE_LINES:   gate_lines_in = csr_wr_data;
            epdsa_pkg::CSR_SOURCE_LINES: source_lines_in = csr_wr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff         <= '0;
         gate_lines_ff   <= CNTW'(1);
         source_lines_ff <= CNTW'(1);
      end else begin
         mode_ff         <= mode_in;
         gate_lines_ff   <= gate_lines_in;
         source_lines_ff <= source_lines_in;
      end
   end

   // line counts after the scramble; source scramble wins over gate scramble
   assign src_scr  = mode_ff[epdsa_pkg::MODE_SRC_SCR];
   assign gate_scr = ~src_scr & mode_ff[epdsa_pkg::MODE_GATE_SCR];

   always_comb begin
      geom.mode = mode_ff;
      if (src_scr) begin
         geom.gate_cnt = {2'b00, gate_lines_ff[CNTW-1:1]};
         geom.src_cnt  = {source_lines_ff, 1'b0};
      end else if (gate_scr) begin
         geom.gate_cnt = {gate_lines_ff, 1'b0};
         geom.src_cnt  = {2'b00, source_lines_ff[CNTW-1:1]};
      end else begin
         geom.gate_cnt = {1'b0, gate_lines_ff};
         geom.src_cnt  = {1'b0, source_lines_ff};
      end
   end

   epdsa_map u_map (
      .clock          (clock),
      .reset          (reset),
      .geom           (geom),
      .in_valid       (req_valid),
      .in_ready       (map_ready),
      .in_gate_line   (req_gate_line),
      .in_source_line (req_source_line),
      .in_pixel       (req_pixel_in),
      .out_valid      (map_valid),
      .out_ready      (rem_ready),
      .out_lane       (map_lane)
   );

   epdsa_rem u_rem (
      .clock     (clock),
      .reset     (reset),
      .geom      (geom),
      .in_valid  (map_valid),
      .in_ready  (rem_ready),
      .in_lane   (map_lane),
      .out_valid (rem_valid),
      .out_ready (addr_ready),
      .out_lane  (rem_lane)
   );

   epdsa_addr u_addr (
      .clock     (clock),
      .reset     (reset),
      .geom      (geom),
      .in_valid  (rem_valid),
      .in_ready  (addr_ready),
      .in_lane   (rem_lane),
      .out_valid (rsp_valid),
      .out_ready (~rsp_stall),
      .out_addr  (rsp_target_index),
      .out_pixel (rsp_pixel_out)
   );

   assign req_stall            = ~map_ready;
   assign rsp_out_gate_lines   = geom.gate_cnt;
   assign rsp_out_source_lines = geom.src_cnt;

`ifndef SYNTHESIS
   a_reset_empties: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_plain_geometry: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (mode_ff == '0) |-> rsp_out_gate_lines == {1'b0, gate_lines_ff})
      else $error("gate line count changed with zero mode");

   a_src_scr_even: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && mode_ff[epdsa_pkg::MODE_SRC_SCR] |-> !rsp_out_source_lines[0])
      else $error("odd source line count under source scramble");
`endif

endmodule
`default_nettype wire

// ----- rtl/epdsa_map.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// epdsa_map - coordinate mapping stages
// Three register stages: row/column scramble and interlace, then mirror and
// column reverse, then the signed dividend of the half-row rotation.
// ----------------------------------------------------------------------------
module epdsa_map (
   input  wire                             clock,
   input  wire                             reset,
   input  wire epdsa_pkg::geom_type        geom,
   input  wire                             in_valid,
   output logic                            in_ready,
   input  wire [epdsa_pkg::COORD_W-1:0]    in_gate_line,
   input  wire [epdsa_pkg::COORD_W-1:0]    in_source_line,
   input  wire [epdsa_pkg::PIX_W-1:0]      in_pixel,
   output logic                            out_valid,
   input  wire                             out_ready,
   output epdsa_pkg::lane_type             out_lane
);

   localparam int GW = epdsa_pkg::GEOM_W;
   localparam int CW = epdsa_pkg::COL_W;
   localparam int RW = epdsa_pkg::ROW_W;
   localparam int KW = epdsa_pkg::COORD_W;

   logic en_a, en_b, en_c;

   // stage a
   logic                         va_ff, va_in;
   logic [RW-1:0]                row_a_ff, row_a_in;
   logic [GW-1:0]                col_a_ff, col_a_in;
   logic [epdsa_pkg::PIX_W-1:0]  pix_a_ff;
   // stage b
   logic                         vb_ff, vb_in;
   logic signed [CW-1:0]         col_b_ff, col_b_in;
   logic [RW-1:0]                row_b_ff;
   logic [epdsa_pkg::PIX_W-1:0]  pix_b_ff;
   // stage c
   logic                         vc_ff, vc_in;
   epdsa_pkg::lane_type          lane_c_ff, lane_c_in;

   logic              src_scr, gate_scr, first_odd;
   logic [RW-1:0]     col_s;
   logic              par;
   logic [GW-1:0]     half_cnt;
   logic signed [CW-1:0] half_s, cnt_s, col_m, dvd;

   assign src_scr   = geom.mode[epdsa_pkg::MODE_SRC_SCR];
   assign gate_scr  = ~src_scr & geom.mode[epdsa_pkg::MODE_GATE_SCR];
   assign first_odd = geom.mode[epdsa_pkg::MODE_FIRST_ODD];
   assign half_cnt  = {1'b0, geom.src_cnt[GW-1:1]};
   assign half_s    = $signed(CW'(half_cnt));
   assign cnt_s     = $signed(CW'(geom.src_cnt));

   assign en_c     = ~vc_ff | out_ready;
   assign en_b     = ~vb_ff | en_c;
   assign en_a     = ~va_ff | en_b;
   assign in_ready = en_a;

   // stage a: row pairs or column pairs folded, then interlace
   always_comb begin
      if (src_scr) begin
         row_a_in = {2'b00, in_gate_line[KW-1:1]};
         col_s    = {in_source_line, in_gate_line[0] ^ first_odd};
      end else if (gate_scr) begin
         row_a_in = {in_gate_line, in_source_line[0] ^ first_odd};
         col_s    = {2'b00, in_source_line[KW-1:1]};
      end else begin
         row_a_in = {1'b0, in_gate_line};
         col_s    = {1'b0, in_source_line};
      end
      par = col_s[0] ^ geom.mode[epdsa_pkg::MODE_IL_ODD];
      if (geom.mode[epdsa_pkg::MODE_INTERLACE]) begin
         col_a_in = GW'({1'b0, col_s[RW-1:1]}) + (par ? half_cnt : '0);
      end else begin
         col_a_in = GW'(col_s);
      end
      va_in = en_a ? in_valid : va_ff;
   end

   // stage b: mirror of the upper half, then column reverse
   always_comb begin
      col_m = $signed(CW'(col_a_ff));
      if (geom.mode[epdsa_pkg::MODE_MIRROR] && (col_a_ff >= half_cnt)) begin
         col_m = cnt_s - CW'(1) - col_m + half_s;
      end
      if (geom.mode[epdsa_pkg::MODE_SRC_REV]) begin
         col_b_in = cnt_s - col_m - CW'(1);
      end else begin
         col_b_in = col_m;
      end
      vb_in = en_b ? va_ff : vb_ff;
   end

   // stage c: rotation dividend split into sign and magnitude
   always_comb begin
      dvd              = col_b_ff + half_s;
      lane_c_in.col    = col_b_ff;
      lane_c_in.neg    = dvd[CW-1];
      lane_c_in.mag    = dvd[CW-1] ? epdsa_pkg::MAG_W'(-dvd) : epdsa_pkg::MAG_W'(dvd);
      lane_c_in.rem    = '0;
      lane_c_in.row    = row_b_ff;
      lane_c_in.pix    = pix_b_ff;
      vc_in = en_c ? vb_ff : vc_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
      end else begin
         va_ff <= va_in;
         vb_ff <= vb_in;
         vc_ff <= vc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en_a) begin
         row_a_ff <= row_a_in;
         col_a_ff <= col_a_in;
         pix_a_ff <= in_pixel;
      end
      if (en_b) begin
         col_b_ff <= col_b_in;
         row_b_ff <= row_a_ff;
         pix_b_ff <= pix_a_ff;
      end
      if (en_c) begin
         lane_c_ff <= lane_c_in;
      end
   end

   assign out_valid = vc_ff;
   assign out_lane  = lane_c_ff;

endmodule
`default_nettype wire

// ----- rtl/epdsa_rem.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// epdsa_rem - pipelined remainder of the rotation dividend
// Restoring remainder by the scrambled column count, a few dividend bits
// resolved in each register stage.
// ----------------------------------------------------------------------------
module epdsa_rem (
   input  wire                        clock,
   input  wire                        reset,
   input  wire epdsa_pkg::geom_type   geom,
   input  wire                        in_valid,
   output logic                       in_ready,
   input  wire epdsa_pkg::lane_type   in_lane,
   output logic                       out_valid,
   input  wire                        out_ready,
   output epdsa_pkg::lane_type        out_lane
);

   localparam int NS = epdsa_pkg::REM_STAGES;
   localparam int NB = epdsa_pkg::REM_BITS;
   localparam int GW = epdsa_pkg::GEOM_W;
   localparam int MW = epdsa_pkg::MAG_W;

   logic [NS-1:0]         v_ff, v_in, en, v_src;
   epdsa_pkg::lane_type   lane_ff [NS];
   epdsa_pkg::lane_type   lane_in [NS];
   epdsa_pkg::lane_type   lane_src [NS];

   function automatic logic [GW-1:0] rem_bits(input logic [GW-1:0] r_in,
                                              input logic [NB-1:0] bits,
                                              input logic [GW-1:0] d);
      logic [GW:0]   t;
      logic [GW-1:0] r;
      r = r_in;
      for (int i = NB - 1; i >= 0; i--) begin
         t = {r, bits[i]};
         if (t >= {1'b0, d}) begin
            t = t - {1'b0, d};
         end
         r = t[GW-1:0];
      end
      return r;
   endfunction

   always_comb begin
      en[NS-1] = ~v_ff[NS-1] | out_ready;
      for (int k = NS - 2; k >= 0; k--) begin
         en[k] = ~v_ff[k] | en[k+1];
      end
      for (int k = 0; k < NS; k++) begin
         v_in[k] = en[k] ? v_src[k] : v_ff[k];
      end
   end

   assign in_ready = en[0];

   for (genvar k = 0; k < NS; k++) begin : g_stage
      if (k == 0) begin : g_first
         assign v_src[k]    = in_valid;
         assign lane_src[k] = in_lane;
      end else begin : g_next
         assign v_src[k]    = v_ff[k-1];
         assign lane_src[k] = lane_ff[k-1];
      end

      always_comb begin
         lane_in[k]     = lane_src[k];
         lane_in[k].rem = rem_bits(lane_src[k].rem,
                                   lane_src[k].mag[MW-1-k*NB -: NB],
                                   geom.src_cnt);
      end

      always_ff @(posedge clock) begin
         if (en[k]) begin
            lane_ff[k] <= lane_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   assign out_valid = v_ff[NS-1];
   assign out_lane  = lane_ff[NS-1];

`ifndef SYNTHESIS
   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      out_valid && (geom.src_cnt != '0) |-> out_lane.rem < geom.src_cnt)
      else $error("remainder not below column count");
`endif

endmodule
`default_nettype wire

// ----- rtl/epdsa_addr.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// epdsa_addr - rotation select, row reverse and linear address
// Three register stages: signed remainder and row reverse, row times line
// length, then the column add into the output register.
// ----------------------------------------------------------------------------
module epdsa_addr (
   input  wire                            clock,
   input  wire                            reset,
   input  wire epdsa_pkg::geom_type       geom,
   input  wire                            in_valid,
   output logic                           in_ready,
   input  wire epdsa_pkg::lane_type       in_lane,
   output logic                           out_valid,
   input  wire                            out_ready,
   output logic [epdsa_pkg::ADDR_W-1:0]   out_addr,
   output logic [epdsa_pkg::PIX_W-1:0]    out_pixel
);

   localparam int GW = epdsa_pkg::GEOM_W;
   localparam int CW = epdsa_pkg::COL_W;
   localparam int SW = epdsa_pkg::ROWS_W;
   localparam int AW = epdsa_pkg::ADDR_W;
   localparam int PW = SW + GW + 1;

   logic en_d, en_e, en_f;

   logic                         vd_ff, vd_in;
   logic signed [CW-1:0]         col_d_ff, col_d_in;
   logic signed [SW-1:0]         row_d_ff, row_d_in;
   logic [epdsa_pkg::PIX_W-1:0]  pix_d_ff;

   logic                         ve_ff, ve_in;
   logic [AW-1:0]                prod_e_ff;
   logic signed [CW-1:0]         col_e_ff;
   logic [epdsa_pkg::PIX_W-1:0]  pix_e_ff;
   logic signed [PW-1:0]         prod;

   logic                         vf_ff, vf_in;
   logic [AW-1:0]                addr_f_ff, addr_f_in;
   logic [epdsa_pkg::PIX_W-1:0]  pix_f_ff;

   logic signed [CW-1:0]         rem_s, row_s;

   assign en_f     = ~vf_ff | out_ready;
   assign en_e     = ~ve_ff | en_f;
   assign en_d     = ~vd_ff | en_e;
   assign in_ready = en_d;

   // remainder takes the sign of the dividend
   always_comb begin
      rem_s = $signed(CW'(in_lane.rem));
      if (in_lane.neg) begin
         rem_s = -rem_s;
      end
      if (geom.mode[epdsa_pkg::MODE_SRC_ROT] && (geom.src_cnt != '0)) begin
         col_d_in = rem_s;
      end else begin
         col_d_in = in_lane.col;
      end
      row_s = $signed(CW'(in_lane.row));
      if (geom.mode[epdsa_pkg::MODE_GATE_REV]) begin
         row_d_in = $signed(SW'(geom.gate_cnt)) - SW'(row_s) - SW'(1);
      end else begin
         row_d_in = SW'(row_s);
      end
      vd_in = en_d ? in_valid : vd_ff;
   end

   assign prod  = row_d_ff * $signed({1'b0, geom.src_cnt});
   assign ve_in = en_e ? vd_ff : ve_ff;

   // address wraps to its width
   assign addr_f_in = prod_e_ff + AW'(col_e_ff);
   assign vf_in     = en_f ? ve_ff : vf_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vd_ff <= 1'b0;
         ve_ff <= 1'b0;
         vf_ff <= 1'b0;
      end else begin
         vd_ff <= vd_in;
         ve_ff <= ve_in;
         vf_ff <= vf_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en_d) begin
         col_d_ff <= col_d_in;
         row_d_ff <= row_d_in;
         pix_d_ff <= in_lane.pix;
      end
      if (en_e) begin
         prod_e_ff <= prod[AW-1:0];
         col_e_ff  <= col_d_ff;
         pix_e_ff  <= pix_d_ff;
      end
      if (en_f) begin
         addr_f_ff <= addr_f_in;
         pix_f_ff  <= pix_e_ff;
      end
   end

   assign out_valid = vf_ff;
   assign out_addr  = addr_f_ff;
   assign out_pixel = pix_f_ff;

endmodule
`default_nettype wire
